// ===== design/sdnv_pkg.sv =====
package sdnv_pkg;

   typedef enum logic [1:0] {
      ST_BUSY  = 2'd0,
      ST_DONE  = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_OVERFLOW   = 2'd1,
      ERR_AFTER_DONE = 2'd2
   } error_type;

   typedef enum logic {
      FUNC_FEED    = 1'b0,
      FUNC_RESTART = 1'b1
   } func_type;

   localparam logic [1:0] MODE_RESET = 2'd3;
   localparam int         COUNT_BITS = 4;

   typedef struct packed {
      status_type            status;
      error_type             error;
      logic [COUNT_BITS-1:0] count;
   } ctrl_type;

endpackage

// ===== design/sdnv_step.sv =====
module sdnv_step #(
   parameter int VALUE_BITS = 64
) (
   input  logic [1:0]            mode,
   input  logic                  func,
   input  logic [7:0]            data_byte,
   input  sdnv_pkg::ctrl_type    cur_ctrl,
   input  logic [VALUE_BITS-1:0] cur_value,
   output sdnv_pkg::ctrl_type    next_ctrl,
   output logic [VALUE_BITS-1:0] next_value
);
   import sdnv_pkg::*;

   logic [VALUE_BITS-1:0] val_mask [4];
   logic [VALUE_BITS-1:0] fit_mask [4];
   logic [COUNT_BITS-1:0] limit_tab [4];

   // per-mode width, capped by the accumulator width
   for (genvar m = 0; m < 4; m++) begin : g_mode
      localparam int WM    = ((8 << m) < VALUE_BITS) ? (8 << m) : VALUE_BITS;
      localparam int LIMIT = (WM + 6) / 7;
      assign val_mask[m]  = {VALUE_BITS{1'b1}} >> (VALUE_BITS - WM);
      // bits that must be clear before another 7-bit shift
      assign fit_mask[m]  = ~({VALUE_BITS{1'b1}} >> (VALUE_BITS - WM + 7));
      assign limit_tab[m] = COUNT_BITS'(LIMIT);
   end

   logic                  fits;
   logic [VALUE_BITS-1:0] merged;

   assign fits = (cur_ctrl.count < limit_tab[mode]) &&
                 ((cur_value & fit_mask[mode]) == '0);

   always_comb begin
      if (cur_ctrl.count == '0) begin
         merged = {{(VALUE_BITS-7){1'b0}}, data_byte[6:0]};
      end else begin
         merged = {cur_value[VALUE_BITS-8:0], data_byte[6:0]};
      end
   end

   always_comb begin
      next_ctrl  = cur_ctrl;
      next_value = cur_value;
      if (func == FUNC_RESTART) begin
         next_ctrl.status = ST_BUSY;
         next_ctrl.error  = ERR_NONE;
         next_ctrl.count  = '0;
         next_value       = '0;
      end else if (cur_ctrl.status != ST_ERROR) begin
         if (!fits) begin
            next_ctrl.status = ST_ERROR;
            next_ctrl.error  = ERR_OVERFLOW;
         end else if (cur_ctrl.status == ST_DONE) begin
            next_ctrl.status = ST_ERROR;
            next_ctrl.error  = ERR_AFTER_DONE;
         end else begin
            next_value = merged & val_mask[mode];
            if (!data_byte[7]) begin
               next_ctrl.status = ST_DONE;
            end
            next_ctrl.count = cur_ctrl.count + COUNT_BITS'(1);
         end
      end
   end

endmodule

// ===== design/sdnv_stream_decoder_core.sv =====
// Streaming decoder for self-delimiting numeric values.
// Request channel (req_valid / req_stall): each word carries req_func and
// req_data_byte. Feed words shift seven bits into the running value; a clear
// bit 7 ends the value. A restart word clears the running value and status.
// Response channel (rsp_valid / rsp_stall): one word per request word, with
// status, error code, the value so far and the count of bytes taken.
// csr_we / csr_wdata set the target width (0=8, 1=16, 2=32, 3=64 bits),
// capped at MAX_VALUE_BITS; write it only while no word is in flight.
// Path: an accepted request word lands in the input register, then is
// decoded into the state/result register, which drives the response.
// Throughput: one word per cycle while no valid response is stalled; the
// shift-merge and width check are combinational between the input register
// and the state register.
// Errors stay until a restart word. Reset clears the value, count, status
// and error and sets the width to 64 bits.
// While rsp_stall holds a valid response, the response and state hold, the
// input register holds its word, and req_stall rises once it is occupied.
module sdnv_stream_decoder_core #(
   parameter int MAX_VALUE_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_decode_status,
   output logic [1:0]  rsp_error_code,
   output logic [63:0] rsp_decoded_value,
   output logic [3:0]  rsp_byte_count
);
   import sdnv_pkg::*;

   logic [1:0]                mode_ff;
   logic                      in_valid_ff;
   logic                      in_func_ff;
   logic [7:0]                in_byte_ff;
   logic                      rsp_valid_ff;
   ctrl_type                  ctrl_ff;
   ctrl_type                  ctrl_in;
   logic [MAX_VALUE_BITS-1:0] acc_ff;
   logic [MAX_VALUE_BITS-1:0] acc_in;
   logic                      advance;
   logic                      req_take;

   // result register is free or drains this cycle
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff <= req_func;
         in_byte_ff <= req_data_byte;
      end
   end

   sdnv_step #(
      .VALUE_BITS (MAX_VALUE_BITS)
   ) u_step (
      .mode       (mode_ff),
      .func       (in_func_ff),
      .data_byte  (in_byte_ff),
      .cur_ctrl   (ctrl_ff),
      .cur_value  (acc_ff),
      .next_ctrl  (ctrl_in),
      .next_value (acc_in)
   );

   // decoder state doubles as the response payload; it moves only on advance
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.status <= ST_BUSY;
         ctrl_ff.error  <= ERR_NONE;
         ctrl_ff.count  <= '0;
         acc_ff         <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
         acc_ff  <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_decode_status = ctrl_ff.status;
   assign rsp_error_code    = ctrl_ff.error;
   assign rsp_decoded_value = 64'(acc_ff);
   assign rsp_byte_count    = ctrl_ff.count;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      ctrl_ff.count <= COUNT_BITS'(10))
      else $error("byte count beyond ten");

   a_error_pairs: assert property (@(posedge clock) disable iff (reset)
      (ctrl_ff.status == ST_ERROR) == (ctrl_ff.error != ERR_NONE))
      else $error("status and error code disagree");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !advance)
      else $error("stalled response overwritten");

   a_sticky_error: assert property (@(posedge clock) disable iff (reset)
      (advance && in_func_ff == FUNC_FEED && ctrl_ff.status == ST_ERROR)
      |=> (ctrl_ff.status == ST_ERROR && $stable(acc_ff)))
      else $error("error state left without restart");

endmodule

// ===== tb/sdnv_decoder_checker.sv =====
module sdnv_decoder_checker #(
   parameter int MAX_VALUE_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_decode_status,
   input  logic [1:0]  rsp_error_code,
   input  logic [63:0] rsp_decoded_value,
   input  logic [3:0]  rsp_byte_count,
   output int          errors,
   output int          outstanding,
   output int          checked,
   output int          done_seen,
   output int          overflow_seen,
   output int          late_byte_seen
);
   import sdnv_pkg::*;

   typedef struct packed {
      status_type            status;
      error_type             error;
      logic [63:0]           value;
      logic [COUNT_BITS-1:0] count;
   } decode_word_type;

   decode_word_type awaited_words[$];

   logic [1:0]            width_mode;
   logic [63:0]           acc_value;
   logic [COUNT_BITS-1:0] acc_count;
   status_type            acc_status;
   error_type             acc_error;
   int                    mismatches;
   int                    n_checked;
   int                    n_done;
   int                    n_overflow;
   int                    n_late;

   function automatic int active_width();
      int w;
      int cap;
      w   = 8 << width_mode;
      cap = MAX_VALUE_BITS;
      if (cap < 8) cap = 8;
      if (cap > 64) cap = 64;
      return (w < cap) ? w : cap;
   endfunction

   // Apply one word to the running decode and return the state it leaves.
   function automatic decode_word_type advance_decoder(logic func, logic [7:0] b);
      int                    w;
      logic [63:0]           mask;
      logic [COUNT_BITS-1:0] limit;
      bit                    fits;
      decode_word_type       r;
      if (func == FUNC_RESTART) begin
         acc_value  = '0;
         acc_count  = '0;
         acc_status = ST_BUSY;
         acc_error  = ERR_NONE;
      end else if (acc_status != ST_ERROR) begin
         w     = active_width();
         mask  = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
         limit = COUNT_BITS'((w + 6) / 7);
         fits  = (acc_count < limit) && (acc_value <= (mask >> 7));
         // overflow wins over a byte after completion
         if (!fits) begin
            acc_status = ST_ERROR;
            acc_error  = ERR_OVERFLOW;
         end else if (acc_status == ST_DONE) begin
            acc_status = ST_ERROR;
            acc_error  = ERR_AFTER_DONE;
         end else begin
            acc_value = (((acc_count == 0) ? 64'd0 : (acc_value << 7)) |
                         {57'd0, b[6:0]}) & mask;
            if (!b[7]) acc_status = ST_DONE;
            acc_count = acc_count + COUNT_BITS'(1);
         end
      end
      r.status = acc_status;
      r.error  = acc_error;
      r.value  = acc_value;
      r.count  = acc_count;
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      decode_word_type want;
      if (reset) begin
         awaited_words.delete();
         width_mode = MODE_RESET;
         acc_value  = '0;
         acc_count  = '0;
         acc_status = ST_BUSY;
         acc_error  = ERR_NONE;
         mismatches = 0;
         n_checked  = 0;
         n_done     = 0;
         n_overflow = 0;
         n_late     = 0;
      end else begin
         if (csr_we) width_mode = csr_wdata;
         // pop before push: a response never belongs to the word taken this edge
         if (rsp_valid && !rsp_stall) begin
            if (awaited_words.size() == 0) begin
               $error("response word with no request waiting");
               mismatches++;
            end else begin
               want = awaited_words.pop_front();
               check_field("decode_status", 64'(want.status), 64'(rsp_decode_status));
               check_field("error_code", 64'(want.error), 64'(rsp_error_code));
               check_field("decoded_value", want.value, rsp_decoded_value);
               check_field("byte_count", 64'(want.count), 64'(rsp_byte_count));
               n_checked++;
               if (want.status == ST_DONE) n_done++;
               if (want.error == ERR_OVERFLOW) n_overflow++;
               if (want.error == ERR_AFTER_DONE) n_late++;
            end
         end
         if (req_valid && !req_stall)
            awaited_words.push_back(advance_decoder(req_func, req_data_byte));
      end
      errors         <= mismatches;
      outstanding    <= awaited_words.size();
      checked        <= n_checked;
      done_seen      <= n_done;
      overflow_seen  <= n_overflow;
      late_byte_seen <= n_late;
   end

endmodule

// ===== tb/sdnv_stream_decoder_core_test.sv =====
module sdnv_stream_decoder_core_test;
   import sdnv_pkg::*;

   localparam int MAX_BITS   = 64;
   localparam int PHASE_LEN  = 60;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        csr_we        = 1'b0;
   logic [1:0]  csr_wdata     = 2'd0;
   logic        req_valid     = 1'b0;
   logic        req_func      = FUNC_FEED;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_stall     = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [1:0]  rsp_decode_status;
   logic [1:0]  rsp_error_code;
   logic [63:0] rsp_decoded_value;
   logic [3:0]  rsp_byte_count;

   int errors;
   int outstanding;
   int checked;
   int done_seen;
   int overflow_seen;
   int late_byte_seen;

   int words_sent  = 0;
   int burst_left  = 0;
   bit sender_gaps = 1'b0;
   int stall_cycle = 0;
   int stall_style = 0;

   sdnv_stream_decoder_core #(
      .MAX_VALUE_BITS(MAX_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_decode_status(rsp_decode_status),
      .rsp_error_code   (rsp_error_code),
      .rsp_decoded_value(rsp_decoded_value),
      .rsp_byte_count   (rsp_byte_count)
   );

   sdnv_decoder_checker #(
      .MAX_VALUE_BITS(MAX_BITS)
   ) u_check (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_decode_status(rsp_decode_status),
      .rsp_error_code   (rsp_error_code),
      .rsp_decoded_value(rsp_decoded_value),
      .rsp_byte_count   (rsp_byte_count),
      .errors           (errors),
      .outstanding      (outstanding),
      .checked          (checked),
      .done_seen        (done_seen),
      .overflow_seen    (overflow_seen),
      .late_byte_seen   (late_byte_seen)
   );

   always #5 clock = ~clock;

   // receiver: drive rsp_stall in one of four randomly chosen stall styles
   always @(negedge clock) begin
      stall_cycle++;
      if (stall_cycle % 97 == 0) stall_style = $urandom_range(0, 3);
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 9) < 7);
         default: rsp_stall <= ((stall_cycle % 5) < 2);
      endcase
   end

   task automatic send_word(func_type f, logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = sender_gaps ? $urandom_range(1, 6) : 0;
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid     <= 1'b1;
      req_func      <= f;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // write the width only once every response is back
   task automatic set_width(logic [1:0] mode);
      @(negedge clock);
      req_valid <= 1'b0;
      wait (outstanding == 0);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // one encoded value with random content; clamp keeps the top byte in range
   task automatic send_value(int w, bit clamp);
      int          limit;
      int          n;
      int          rem;
      logic [7:0]  b;
      limit = (w + 6) / 7;
      n     = ($urandom_range(0, 6) == 0) ? limit + 1 : $urandom_range(1, limit);
      rem   = w - 7 * (n - 1);
      for (int i = 0; i < n; i++) begin
         b = 8'($urandom);
         if ($urandom_range(0, 3) == 0) b[6:0] = 7'd0;
         if (i == 0 && clamp && rem < 7)
            b[6:0] = (rem > 0) ? (b[6:0] & ((7'd1 << rem) - 7'd1)) : 7'd0;
         b[7] = (i != n - 1);
         send_word(FUNC_FEED, b);
      end
   endtask

   initial begin
      logic [1:0] phase_modes[8];
      int         w;
      int         start;
      int         pick;
      phase_modes = '{2'd3, 2'd1, 2'd0, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 64-bit width after reset: restart ignores its byte, single byte,
      // byte after completion, sticky error, full ten-byte all-ones value
      send_word(FUNC_RESTART, 8'hFF);
      send_word(FUNC_FEED, 8'h00);
      send_word(FUNC_FEED, 8'h05);
      send_word(FUNC_FEED, 8'h80);
      send_word(FUNC_RESTART, 8'h00);
      send_word(FUNC_FEED, 8'h81);
      repeat (8) send_word(FUNC_FEED, 8'hFF);
      send_word(FUNC_FEED, 8'h7F);

      // 8-bit width: 255 fits, a third byte overflows the count even after
      // completion, then a too-large value overflows before its next byte
      set_width(2'd0);
      send_word(FUNC_RESTART, 8'h00);
      send_word(FUNC_FEED, 8'h81);
      send_word(FUNC_FEED, 8'h7F);
      send_word(FUNC_FEED, 8'h00);
      send_word(FUNC_FEED, 8'h80);
      send_word(FUNC_RESTART, 8'h00);
      send_word(FUNC_FEED, 8'h05);
      send_word(FUNC_FEED, 8'h01);

      foreach (phase_modes[p]) begin
         set_width(phase_modes[p]);
         w = 8 << phase_modes[p];
         if (w > MAX_BITS) w = MAX_BITS;
         sender_gaps = ($urandom_range(0, 2) != 0);
         start = words_sent;
         while (words_sent - start < PHASE_LEN) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               send_word(($urandom_range(0, 4) == 0) ? FUNC_RESTART : FUNC_FEED,
                         8'($urandom));
            end else begin
               if (pick >= 25) send_word(FUNC_RESTART, 8'($urandom));
               send_value(w, $urandom_range(0, 3) != 0);
               if ($urandom_range(0, 5) == 0) send_word(FUNC_FEED, 8'($urandom));
            end
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (outstanding == 0);
      repeat (8) @(posedge clock);

      $display("Checked %0d responses over all four widths: %0d done, %0d overflow,",
               checked, done_seen, overflow_seen);
      $display("%0d byte-after-done, with sender gaps and receiver stalls mixed in.",
               late_byte_seen);
      if (errors == 0 && outstanding == 0) begin
         $display("** sdnv_stream_decoder_core: PASSED **");
      end else begin
         $display("** sdnv_stream_decoder_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timed out waiting for the decoder.");
      $display("** sdnv_stream_decoder_core: FAILED **");
      $finish;
   end

endmodule
